// ===== rtl/core/dsw_pkg.sv =====
// Shared constants and types for the dual stability window variance block.
// No dependencies; imported by the top level.
package dsw_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_EVAL_START = 2'd1,
    CFG_VAR_LIMIT  = 2'd2,
    CFG_PASS_RATIO = 2'd3
  } cfg_idx_e;

  localparam logic [6:0]  WINDOW_LEN_RST = 7'd64;
  localparam logic [31:0] EVAL_START_RST = 32'd0;
  localparam logic [63:0] VAR_LIMIT_RST  = 64'd1152921504606847;
  localparam logic [30:0] PASS_RATIO_RST = 31'd966367642;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 104;

  localparam int unsigned SUM_W     = 48;
  localparam int unsigned RATIO_W   = 32;
  localparam int unsigned FRAC_BITS = 30;

  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

endpackage

// ===== rtl/core/dual_stability_window_variance.sv =====
// Top level of the dual stability window variance block; uses dsw_pkg and dsw_ram.
// The ratio ring lives in one dsw_ram; one shift-subtract divider and one
// shift-add multiplier are shared by all steps of an item.
//
// Each item divides partial_sum by total_sum into a saturated Q2.30 ratio (zero when
// total_sum is zero), stores it in ring slot sample_number mod window length, and, once
// evaluation has started, computes the sample variance of the window in Q4.60. Items are
// handled one at a time. An item is accepted, passes through serial division for slot and
// ratio, the ring write and the output register, plus, when the variance is evaluated, a
// walk of the ring (one RAM read a cycle), two passes of serial multiplication, an overflow
// check and one divider pass as long as the widest dividend (78 bits at a 64-entry window).
// The bit-serial divider does most of the work. After reset the ring is cleared, during
// which no item is taken. A new item may be taken while the previous result still waits on
// the output register.
module dual_stability_window_variance #(
  parameter int unsigned MAX_WINDOW = dsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dsw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dsw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // partial_sum[47:0], total_sum[95:48], sample_number[127:96]
  input  logic [dsw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // stable[0], window_variance[64:1], current_ratio[96:65], zero_divisor[97], zeros above
  output logic [dsw_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import dsw_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_WINDOW);
  localparam int unsigned LW   = AW + 1;
  localparam int unsigned SQW  = 63 + LW;
  localparam int unsigned SUMW = 32 + LW;
  localparam int unsigned MRW  = 31 + LW;
  localparam int unsigned DW   = SQW + LW;
  localparam int unsigned RDW  = SUM_W + FRAC_BITS;
  localparam int unsigned DIVW = (DW > RDW) ? DW : RDW;
  localparam int unsigned CW   = $clog2(DIVW + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_WRITE, ST_ACC, ST_MUL, ST_DIFF, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    JOB_MOD, JOB_RATIO, JOB_VAR, JOB_SQN, JOB_SUM2
  } job_e;

  state_e state_q;
  job_e   job_q;

  logic [6:0]  window_len_q;
  logic [31:0] eval_start_q;
  logic [63:0] var_limit_q;
  logic [30:0] pass_ratio_q;

  logic [SUM_W-1:0] mp_q, mt_q;
  logic             neg_q, zero_q;
  logic [31:0]      sn_q;
  logic [LW-1:0]    n_q, idx_q;
  logic [AW-1:0]    slot_q;
  logic [31:0]      ratio_q;
  logic [63:0]      var_q;

  logic [DIVW-1:0]  div_d_q, div_quo_q;
  logic [SUM_W-1:0] div_v_q;
  logic [SUM_W:0]   div_r_q;
  logic [CW-1:0]    cnt_q;

  logic [DW-1:0]    mul_md_q, mul_acc_q, a_q;
  logic [MRW-1:0]   mul_mr_q;
  logic [2*LW-1:0]  top_q;

  logic             p1_vld_q, p2_vld_q;
  logic [63:0]      x2_q;
  logic [31:0]      xs_q;
  logic [SQW-1:0]   sq_q;
  logic [SUMW-1:0]  sum_q;

  logic             out_vld_q;
  logic             out_stable_q, out_zero_q;
  logic [63:0]      out_var_q;
  logic [31:0]      out_ratio_q;

  logic [RATIO_W-1:0] ram_rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [RATIO_W-1:0] ram_wdata;

  dsw_ram #(.WIDTH(RATIO_W), .DEPTH(MAX_WINDOW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign ram_addr  = (state_q == ST_WRITE) ? slot_q : idx_q[AW-1:0];
  assign ram_wdata = (state_q == ST_WRITE) ? ratio_q : '0;

  // Divider step: one quotient bit per cycle.
  logic [SUM_W:0]  r_sh, r_n;
  logic            q_bit;
  logic [DIVW-1:0] quo_n;
  always_comb begin
    r_sh  = {div_r_q[SUM_W-1:0], div_d_q[DIVW-1]};
    q_bit = r_sh >= {1'b0, div_v_q};
    r_n   = q_bit ? (r_sh - {1'b0, div_v_q}) : r_sh;
    quo_n = {div_quo_q[DIVW-2:0], q_bit};
  end

  // Signed, saturated Q2.30 ratio from the unsigned quotient.
  logic [31:0] ratio_sat;
  always_comb begin
    if (!neg_q) begin
      ratio_sat = (|quo_n[DIVW-1:31]) ? 32'h7FFF_FFFF : {1'b0, quo_n[30:0]};
    end else if ((|quo_n[DIVW-1:32]) || (quo_n[31:0] > 32'h8000_0000)) begin
      ratio_sat = 32'h8000_0000;
    end else begin
      ratio_sat = 32'd0 - quo_n[31:0];
    end
  end

  logic [DW-1:0] acc_n;
  assign acc_n = mul_mr_q[0] ? (mul_acc_q + mul_md_q) : mul_acc_q;

  logic [31:0] ax;
  assign ax = ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata;

  logic [SUMW-1:0] sum_abs;
  assign sum_abs = sum_q[SUMW-1] ? (SUMW'(0) - sum_q) : sum_q;

  logic [DW-1:0]   diff;
  logic [DIVW-1:0] top_sh;
  assign diff   = a_q - mul_acc_q;
  assign top_sh = DIVW'(top_q) << 64;

  logic [SUM_W-1:0] p_in, t_in;
  logic [31:0]      sn_in;
  logic [LW-1:0]    n_in;
  assign p_in  = s_axis_tdata[47:0];
  assign t_in  = s_axis_tdata[95:48];
  assign sn_in = s_axis_tdata[127:96];
  always_comb begin
    if (window_len_q < 7'd2) begin
      n_in = LW'(2);
    end else if (32'(window_len_q) > MAX_WINDOW) begin
      n_in = LW'(MAX_WINDOW);
    end else begin
      n_in = LW'(window_len_q);
    end
  end

  logic eval_go;
  assign eval_go = {1'b0, sn_q} > ({1'b0, eval_start_q} + 33'(n_q));

  logic stable_d;
  assign stable_d = !zero_q && (var_q < var_limit_q) &&
                    ($signed(ratio_q) >= $signed({1'b0, pass_ratio_q}));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_zero_q, out_ratio_q, out_var_q, out_stable_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      job_q        <= JOB_MOD;
      window_len_q <= WINDOW_LEN_RST;
      eval_start_q <= EVAL_START_RST;
      var_limit_q  <= VAR_LIMIT_RST;
      pass_ratio_q <= PASS_RATIO_RST;
      idx_q        <= '0;
      cnt_q        <= '0;
      p1_vld_q     <= 1'b0;
      p2_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW_LEN: window_len_q <= cfg_data_i[6:0];
          CFG_EVAL_START: eval_start_q <= cfg_data_i[31:0];
          CFG_VAR_LIMIT:  var_limit_q  <= cfg_data_i;
          CFG_PASS_RATIO: pass_ratio_q <= cfg_data_i[30:0];
          default:        window_len_q <= window_len_q;
        endcase
      end

      // In ST_DONE the output register is handled by the state itself.
      if (out_vld_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          idx_q <= idx_q + LW'(1);
          if (idx_q == LW'(MAX_WINDOW - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mp_q      <= p_in[SUM_W-1] ? (SUM_W'(0) - p_in) : p_in;
            mt_q      <= t_in[SUM_W-1] ? (SUM_W'(0) - t_in) : t_in;
            neg_q     <= p_in[SUM_W-1] ^ t_in[SUM_W-1];
            zero_q    <= (t_in == '0);
            sn_q      <= sn_in;
            n_q       <= n_in;
            div_d_q   <= {sn_in, (DIVW-32)'(0)};
            div_v_q   <= SUM_W'(n_in);
            div_r_q   <= '0;
            div_quo_q <= '0;
            cnt_q     <= CW'(32);
            job_q     <= JOB_MOD;
            state_q   <= ST_DIV;
          end
        end

        ST_DIV: begin
          div_d_q   <= div_d_q << 1;
          div_r_q   <= r_n;
          div_quo_q <= quo_n;
          cnt_q     <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            case (job_q)
              JOB_MOD: begin
                slot_q <= r_n[AW-1:0];
                if (zero_q) begin
                  ratio_q <= '0;
                  state_q <= ST_WRITE;
                end else begin
                  div_d_q   <= DIVW'({mp_q, FRAC_BITS'(0)}) << (DIVW - RDW);
                  div_v_q   <= mt_q;
                  div_r_q   <= '0;
                  div_quo_q <= '0;
                  cnt_q     <= CW'(RDW);
                  job_q     <= JOB_RATIO;
                end
              end
              JOB_RATIO: begin
                ratio_q <= ratio_sat;
                state_q <= ST_WRITE;
              end
              default: begin
                var_q   <= quo_n[63:0];
                state_q <= ST_DONE;
              end
            endcase
          end
        end

        ST_WRITE: begin
          if (eval_go) begin
            idx_q    <= '0;
            sum_q    <= '0;
            sq_q     <= '0;
            p1_vld_q <= 1'b0;
            p2_vld_q <= 1'b0;
            top_q    <= (2*LW)'(n_q) * (2*LW)'(n_q - LW'(1));
            state_q  <= ST_ACC;
          end else begin
            var_q   <= ONE_Q60;
            state_q <= ST_DONE;
          end
        end

        ST_ACC: begin
          // Read one entry a cycle; square it the next cycle, add it the one after.
          p1_vld_q <= (idx_q < n_q);
          if (idx_q < n_q) begin
            idx_q <= idx_q + LW'(1);
          end
          p2_vld_q <= p1_vld_q;
          x2_q     <= 64'(ax) * 64'(ax);
          xs_q     <= ram_rdata;
          if (p2_vld_q) begin
            sum_q <= sum_q + SUMW'($signed(xs_q));
            sq_q  <= sq_q + SQW'(x2_q);
          end
          if ((idx_q == n_q) && !p1_vld_q && !p2_vld_q) begin
            mul_md_q  <= DW'(sq_q);
            mul_mr_q  <= MRW'(n_q);
            mul_acc_q <= '0;
            cnt_q     <= CW'(MRW);
            job_q     <= JOB_SQN;
            state_q   <= ST_MUL;
          end
        end

        ST_MUL: begin
          mul_acc_q <= acc_n;
          mul_md_q  <= mul_md_q << 1;
          mul_mr_q  <= mul_mr_q >> 1;
          cnt_q     <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            if (job_q == JOB_SQN) begin
              a_q       <= acc_n;
              mul_md_q  <= DW'(sum_abs);
              mul_mr_q  <= MRW'(sum_abs);
              mul_acc_q <= '0;
              cnt_q     <= CW'(MRW);
              job_q     <= JOB_SUM2;
            end else begin
              state_q <= ST_DIFF;
            end
          end
        end

        ST_DIFF: begin
          if (DIVW'(diff) >= top_sh) begin
            var_q   <= '1;
            state_q <= ST_DONE;
          end else begin
            div_d_q   <= DIVW'(diff);
            div_v_q   <= SUM_W'(top_q);
            div_r_q   <= '0;
            div_quo_q <= '0;
            cnt_q     <= CW'(DIVW);
            job_q     <= JOB_VAR;
            state_q   <= ST_DIV;
          end
        end

        ST_DONE: begin
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q    <= 1'b1;
            out_stable_q <= stable_d;
            out_var_q    <= var_q;
            out_ratio_q  <= ratio_q;
            out_zero_q   <= zero_q;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during ring clear");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (LW'(slot_q) < n_q))
    else $error("ring slot outside window");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_r_q < {1'b0, div_v_q}))
    else $error("divider remainder not below divisor");

  a_done_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_vld_q || m_axis_tready)) |=> out_vld_q)
    else $error("finished item not presented");

endmodule

// ===== rtl/core/dsw_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module dsw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
